[rtl/ssmp_pkg.sv]
// ssmp_pkg: shared types, constants and parameter defaults of the
// spaced-seed mutation predictor; no dependencies
package ssmp_pkg;

   localparam int ROW_W     = 12;
   localparam int OFF_W     = 8;
   localparam int POS_W     = 9;
   localparam int EPOCH_W   = 8;
   localparam int OUT_MAX   = 8;
   localparam int SLOT_IN_W = 3;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam int WL_W      = 6;
   localparam int PL_W      = 4;

   localparam int READ_MAX_DEF    = 128;
   localparam int SHAPE_MAX_DEF   = 32;
   localparam int PATTERN_MAX_DEF = 12;
   localparam int SLOTS_DEF       = 8;

   localparam logic [OFF_W-1:0] END_MARK = 8'hFF;

   localparam logic OP_FLAG  = 1'b0;
   localparam logic OP_TABLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_CARE_MASK      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 2'd2;

   typedef struct packed {
      logic             valid;
      logic             lookup;
      logic             end_read;
      logic [ROW_W-1:0] row;
      logic [POS_W-1:0] ppos;
   } lookup_req_type;

   typedef struct packed {
      logic                 en;
      logic [ROW_W-1:0]     row;
      logic [SLOT_IN_W-1:0] slot;
      logic [OFF_W-1:0]     offset;
   } table_wr_type;

   typedef struct packed {
      logic busy;
      logic sweeping;
   } seq_status_type;

endpackage

[rtl/spaced_seed_mutation_predictor_unit.sv]
// spaced_seed_mutation_predictor_unit: top level, control registers and channels
// depends on ssmp_pkg, ssmp_hit, ssmp_seq, ssmp_ram
// a lookup scans up to min(SLOTS,8) table slots at one per cycle while the output is not
// stalled, and the next item is taken only after the scan ends; one table/map port pair
// serves the scan; table words and flags without lookup never start a scan
// reset: table and map clearing sweep with req_ready low; every 255th
// read end starts a map clearing sweep with req_ready low
module spaced_seed_mutation_predictor_unit #(
   parameter int READ_MAX    = ssmp_pkg::READ_MAX_DEF,
   parameter int SHAPE_MAX   = ssmp_pkg::SHAPE_MAX_DEF,
   parameter int PATTERN_MAX = ssmp_pkg::PATTERN_MAX_DEF,
   parameter int SLOTS       = ssmp_pkg::SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic                              req_mutated,
   input  logic                              req_last_in_read,
   input  logic [ssmp_pkg::ROW_W-1:0]        req_table_pattern,
   input  logic [ssmp_pkg::SLOT_IN_W-1:0]    req_table_slot,
   input  logic [ssmp_pkg::OFF_W-1:0]        req_table_offset,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ssmp_pkg::POS_W-1:0]        rsp_predicted_position,
   output logic                              rsp_last,
   input  logic                              csr_write_enable,
   input  logic [ssmp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ssmp_pkg::CSR_W-1:0]        csr_write_data
);
   import ssmp_pkg::*;

   logic [CSR_W-1:0] care_mask_ff;
   logic [WL_W-1:0]  window_length_ff;
   logic [PL_W-1:0]  pattern_length_ff;
   logic             accept, flag_acc;
   lookup_req_type   lookup_req;
   table_wr_type     table_wr;
   seq_status_type   status;

   always_ff @(posedge clock) begin
      if (reset) begin
         care_mask_ff      <= '1;
         window_length_ff  <= WL_W'(1);
         pattern_length_ff <= PL_W'(8);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CARE_MASK: begin
               care_mask_ff <= csr_write_data;
            end
            CSR_WINDOW_LENGTH: begin
               window_length_ff <= csr_write_data[WL_W-1:0];
            end
            CSR_PATTERN_LENGTH: begin
               pattern_length_ff <= csr_write_data[PL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign accept   = req_valid && req_ready;
   assign flag_acc = accept && (req_opcode == OP_FLAG);

   always_comb begin
      table_wr.en     = accept && (req_opcode == OP_TABLE);
      table_wr.row    = req_table_pattern;
      table_wr.slot   = req_table_slot;
      table_wr.offset = req_table_offset;
   end

   ssmp_hit #(
      .READ_MAX    (READ_MAX),
      .SHAPE_MAX   (SHAPE_MAX),
      .PATTERN_MAX (PATTERN_MAX)
   ) u_hit (
      .clock          (clock),
      .reset          (reset),
      .accept         (flag_acc),
      .mutated        (req_mutated),
      .last_in_read   (req_last_in_read),
      .care_mask      (care_mask_ff),
      .window_length  (window_length_ff),
      .pattern_length (pattern_length_ff),
      .lookup_req     (lookup_req)
   );

   ssmp_seq #(.SLOTS(SLOTS)) u_seq (
      .clock                  (clock),
      .reset                  (reset),
      .lookup_req             (lookup_req),
      .table_wr               (table_wr),
      .req_ready              (req_ready),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_predicted_position (rsp_predicted_position),
      .rsp_last               (rsp_last),
      .status                 (status)
   );

   // no item taken during a clearing sweep
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      status.sweeping |-> !req_ready)
      else $error("item accepted during clearing sweep");

   // reset always starts the clearing sweep
   a_sweep_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> status.sweeping)
      else $error("no clearing sweep after reset");

   // a table word never starts a scan
   a_table_word_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == OP_TABLE)) |=> !status.busy)
      else $error("table word started a scan");

   // no item is taken while a scan is in progress
   a_busy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> !req_ready)
      else $error("item accepted while scan in progress");

endmodule

[rtl/ssmp_ram.sv]
// ssmp_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module ssmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ssmp_hit.sv]
// ssmp_hit: read window, hit test against the shape and pattern window
// depends on ssmp_pkg
module ssmp_hit #(
   parameter int READ_MAX    = ssmp_pkg::READ_MAX_DEF,
   parameter int SHAPE_MAX   = ssmp_pkg::SHAPE_MAX_DEF,
   parameter int PATTERN_MAX = ssmp_pkg::PATTERN_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          mutated,
   input  logic                          last_in_read,
   input  logic [ssmp_pkg::CSR_W-1:0]    care_mask,
   input  logic [ssmp_pkg::WL_W-1:0]     window_length,
   input  logic [ssmp_pkg::PL_W-1:0]     pattern_length,
   output ssmp_pkg::lookup_req_type      lookup_req
);
   import ssmp_pkg::*;

   localparam int RP_W = $clog2(READ_MAX + 1);

   logic [SHAPE_MAX-1:0]   rw_ff, rw_in, rw_new;
   logic [PATTERN_MAX-1:0] hw_ff, hw_in, hw_new, pmask;
   logic [RP_W-1:0]        rp_ff, rp_in, rp_new;
   logic [WL_W-1:0]        wl_eff;
   logic [4:0]             pl_eff;
   logic [CSR_W-1:0]       care_rev, aligned, wmask;
   logic [16:0]            pmask_wide;
   logic [15:0]            hw_ext;
   logic [9:0]             hits;
   logic                   active, hit, have_hit, have_pat;

   always_comb begin
      if (window_length == '0) begin
         wl_eff = WL_W'(1);
      end else if (window_length > WL_W'(SHAPE_MAX)) begin
         wl_eff = WL_W'(SHAPE_MAX);
      end else begin
         wl_eff = window_length;
      end
      if (pattern_length == '0) begin
         pl_eff = 5'd1;
      end else if ({1'b0, pattern_length} > 5'(PATTERN_MAX)) begin
         pl_eff = 5'(PATTERN_MAX);
      end else begin
         pl_eff = {1'b0, pattern_length};
      end
   end

   // shape position k lines up with window bit wl-1-k
   always_comb begin
      for (int i = 0; i < CSR_W; i++) begin
         care_rev[CSR_W-1-i] = care_mask[i];
      end
   end

   assign aligned  = care_rev >> (WL_W'(CSR_W) - wl_eff);
   assign wmask    = {CSR_W{1'b1}} >> (WL_W'(CSR_W) - wl_eff);
   assign rw_new   = (rw_ff << 1) | SHAPE_MAX'(mutated);
   assign hit      = ~|(CSR_W'(rw_new) & ~aligned & wmask);
   assign rp_new   = rp_ff + RP_W'(1);
   assign active   = rp_ff < RP_W'(READ_MAX);
   assign have_hit = 10'(rp_new) >= 10'(wl_eff);
   assign hits     = 10'(rp_new) - 10'(wl_eff) + 10'd1;

   assign pmask_wide = (17'd1 << pl_eff) - 17'd1;
   assign pmask      = pmask_wide[PATTERN_MAX-1:0];
   assign hw_new     = ((hw_ff << 1) | PATTERN_MAX'(hit)) & pmask;
   assign have_pat   = have_hit && (hits >= 10'(pl_eff));
   assign hw_ext     = 16'(hw_new);

   always_comb begin
      lookup_req.valid    = accept;
      lookup_req.lookup   = active && have_pat && (hw_new != '0) && (hw_new != pmask);
      lookup_req.end_read = last_in_read;
      lookup_req.row      = hw_ext[ROW_W-1:0];
      lookup_req.ppos     = POS_W'(hits - 10'(pl_eff));
   end

   always_comb begin
      rw_in = rw_ff;
      hw_in = hw_ff;
      rp_in = rp_ff;
      if (accept) begin
         if (last_in_read) begin
            rw_in = '0;
            hw_in = '0;
            rp_in = '0;
         end else if (active) begin
            rw_in = rw_new;
            rp_in = rp_new;
            if (have_hit) begin
               hw_in = hw_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rw_ff <= '0;
         hw_ff <= '0;
         rp_ff <= '0;
      end else begin
         rw_ff <= rw_in;
         hw_ff <= hw_in;
         rp_ff <= rp_in;
      end
   end

endmodule

[rtl/ssmp_seq.sv]
// ssmp_seq: prediction table and seen-position map memories, slot scan
// pipeline, clearing sweeps and result register; depends on ssmp_pkg, ssmp_ram
module ssmp_seq #(
   parameter int SLOTS = ssmp_pkg::SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ssmp_pkg::lookup_req_type      lookup_req,
   input  ssmp_pkg::table_wr_type        table_wr,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ssmp_pkg::POS_W-1:0]    rsp_predicted_position,
   output logic                          rsp_last,
   output ssmp_pkg::seq_status_type      status
);
   import ssmp_pkg::*;

   localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SCAN      = (SLOTS < OUT_MAX) ? SLOTS : OUT_MAX;
   localparam int CNT_W     = $clog2(SCAN + 1);
   localparam int TAB_AW    = ROW_W + SLOT_W;
   localparam int TAB_DEPTH = 1 << TAB_AW;
   localparam int MAP_DEPTH = 1 << POS_W;

   logic                busy_ff, busy_in;
   logic                issuing_ff, issuing_in;
   logic [CNT_W-1:0]    s_ff, s_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [POS_W-1:0]    ppos_ff, ppos_in;
   logic                end_ff, end_in;
   logic                v_b_ff, v_b_in;
   logic                v_c_ff, v_c_in;
   logic [POS_W-1:0]    pos_c_ff, pos_c_in;
   logic                fwd_c_ff, fwd_c_in;
   logic                p_valid_ff, p_valid_in;
   logic [POS_W-1:0]    p_pos_ff, p_pos_in;
   logic                o_valid_ff, o_valid_in;
   logic [POS_W-1:0]    o_pos_ff, o_pos_in;
   logic                o_last_ff, o_last_in;
   logic [EPOCH_W-1:0]  epoch_ff, epoch_in;
   logic                tab_sweep_ff, tab_sweep_in;
   logic                map_sweep_ff, map_sweep_in;
   logic [TAB_AW-1:0]   cnt_ff, cnt_in;

   logic [OFF_W-1:0]    tab_q;
   logic [EPOCH_W-1:0]  map_q;
   logic                tab_wr_en, tab_rd_en, map_wr_en, map_rd_en;
   logic [TAB_AW-1:0]   tab_wr_addr, tab_rd_addr;
   logic [OFF_W-1:0]    tab_wr_data;
   logic [POS_W-1:0]    map_wr_addr, pos_b;
   logic [EPOCH_W-1:0]  map_wr_data;
   logic [5:0]          slot_ext;
   logic                stop, emit_c, o_free, adv, finish, sweeping, bump;

   assign stop     = v_b_ff && (tab_q == END_MARK);
   assign pos_b    = ppos_ff + POS_W'(tab_q);
   assign emit_c   = v_c_ff && !fwd_c_ff && (map_q != epoch_ff);
   assign o_free   = !o_valid_ff || rsp_ready;
   assign adv      = !(emit_c && p_valid_ff && !o_free);
   assign finish   = busy_ff && !issuing_ff && !v_b_ff && !v_c_ff && (!p_valid_ff || o_free);
   assign sweeping = tab_sweep_ff || map_sweep_ff;
   assign bump     = (lookup_req.valid && !lookup_req.lookup && lookup_req.end_read)
                     || (finish && end_ff);
   assign slot_ext = 6'(table_wr.slot);

   // table port
   assign tab_rd_en   = busy_ff && adv && issuing_ff;
   assign tab_rd_addr = {row_ff, SLOT_W'(s_ff)};
   always_comb begin
      if (tab_sweep_ff) begin
         tab_wr_en   = 1'b1;
         tab_wr_addr = cnt_ff;
         tab_wr_data = END_MARK;
      end else begin
         tab_wr_en   = table_wr.en && (slot_ext < 6'(SLOTS));
         tab_wr_addr = {table_wr.row, SLOT_W'(slot_ext)};
         tab_wr_data = table_wr.offset;
      end
   end

   // seen map port, entry counts as set when it holds the current epoch
   assign map_rd_en = busy_ff && adv && v_b_ff && !stop;
   always_comb begin
      if (map_sweep_ff) begin
         map_wr_en   = 1'b1;
         map_wr_addr = cnt_ff[POS_W-1:0];
         map_wr_data = '0;
      end else begin
         map_wr_en   = busy_ff && adv && emit_c;
         map_wr_addr = pos_c_ff;
         map_wr_data = epoch_ff;
      end
   end

   ssmp_ram #(.WIDTH(OFF_W), .DEPTH(TAB_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (tab_wr_en),
      .wr_addr (tab_wr_addr),
      .wr_data (tab_wr_data),
      .rd_en   (tab_rd_en),
      .rd_addr (tab_rd_addr),
      .rd_data (tab_q)
   );

   ssmp_ram #(.WIDTH(EPOCH_W), .DEPTH(MAP_DEPTH)) u_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (pos_b),
      .rd_data (map_q)
   );

   always_comb begin
      busy_in      = busy_ff;
      issuing_in   = issuing_ff;
      s_in         = s_ff;
      row_in       = row_ff;
      ppos_in      = ppos_ff;
      end_in       = end_ff;
      v_b_in       = v_b_ff;
      v_c_in       = v_c_ff;
      pos_c_in     = pos_c_ff;
      fwd_c_in     = fwd_c_ff;
      p_valid_in   = p_valid_ff;
      p_pos_in     = p_pos_ff;
      o_valid_in   = o_valid_ff;
      o_pos_in     = o_pos_ff;
      o_last_in    = o_last_ff;
      epoch_in     = epoch_ff;
      tab_sweep_in = tab_sweep_ff;
      map_sweep_in = map_sweep_ff;
      cnt_in       = cnt_ff;

      if (rsp_ready) begin
         o_valid_in = 1'b0;
      end

      // slot scan: issue table read, then map read, then decide
      if (busy_ff && adv) begin
         if (issuing_ff) begin
            s_in = s_ff + CNT_W'(1);
            if (stop || (s_ff == CNT_W'(SCAN - 1))) begin
               issuing_in = 1'b0;
            end
         end
         v_b_in   = issuing_ff && !stop;
         v_c_in   = v_b_ff && !stop;
         pos_c_in = pos_b;
         fwd_c_in = emit_c && (pos_c_ff == pos_b);
         if (emit_c) begin
            p_valid_in = 1'b1;
            p_pos_in   = pos_c_ff;
            if (p_valid_ff) begin
               o_valid_in = 1'b1;
               o_pos_in   = p_pos_ff;
               o_last_in  = 1'b0;
            end
         end
      end

      // held word goes out marked last
      if (finish) begin
         busy_in    = 1'b0;
         p_valid_in = 1'b0;
         if (p_valid_ff) begin
            o_valid_in = 1'b1;
            o_pos_in   = p_pos_ff;
            o_last_in  = 1'b1;
         end
      end

      if (lookup_req.valid && lookup_req.lookup) begin
         busy_in    = 1'b1;
         issuing_in = 1'b1;
         s_in       = '0;
         row_in     = lookup_req.row;
         ppos_in    = lookup_req.ppos;
         end_in     = lookup_req.end_read;
      end

      if (sweeping) begin
         cnt_in = cnt_ff + TAB_AW'(1);
         if (map_sweep_ff && (cnt_ff[POS_W-1:0] == '1)) begin
            map_sweep_in = 1'b0;
         end
         if (tab_sweep_ff && (cnt_ff == '1)) begin
            tab_sweep_in = 1'b0;
         end
      end

      // end of read: next epoch, map sweep on wrap
      if (bump) begin
         if (epoch_ff == '1) begin
            map_sweep_in = 1'b1;
            cnt_in       = '0;
            epoch_in     = EPOCH_W'(1);
         end else begin
            epoch_in = epoch_ff + EPOCH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         issuing_ff   <= 1'b0;
         v_b_ff       <= 1'b0;
         v_c_ff       <= 1'b0;
         p_valid_ff   <= 1'b0;
         o_valid_ff   <= 1'b0;
         epoch_ff     <= EPOCH_W'(1);
         tab_sweep_ff <= 1'b1;
         map_sweep_ff <= 1'b1;
         cnt_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         issuing_ff   <= issuing_in;
         v_b_ff       <= v_b_in;
         v_c_ff       <= v_c_in;
         p_valid_ff   <= p_valid_in;
         o_valid_ff   <= o_valid_in;
         epoch_ff     <= epoch_in;
         tab_sweep_ff <= tab_sweep_in;
         map_sweep_ff <= map_sweep_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff     <= s_in;
      row_ff   <= row_in;
      ppos_ff  <= ppos_in;
      end_ff   <= end_in;
      pos_c_ff <= pos_c_in;
      fwd_c_ff <= fwd_c_in;
      p_pos_ff <= p_pos_in;
      o_pos_ff <= o_pos_in;
      o_last_ff <= o_last_in;
   end

   assign req_ready              = !busy_ff && !sweeping;
   assign rsp_valid              = o_valid_ff;
   assign rsp_predicted_position = o_pos_ff;
   assign rsp_last               = o_last_ff;
   assign status.busy            = busy_ff;
   assign status.sweeping        = sweeping;

endmodule

[bench/tb_spaced_seed_mutation_predictor_unit.sv]
// tb_spaced_seed_mutation_predictor_unit: self-checking bench for the spaced-seed
// mutation predictor; predicts every position word and compares in order
// depends on ssmp_pkg and spaced_seed_mutation_predictor_unit
`timescale 1ns / 100ps

module tb_spaced_seed_mutation_predictor_unit;
   import ssmp_pkg::*;

   localparam int unsigned READ_LIMIT    = READ_MAX_DEF;
   localparam int unsigned SHAPE_LIMIT   = SHAPE_MAX_DEF;
   localparam int unsigned PATTERN_LIMIT = PATTERN_MAX_DEF;
   localparam int unsigned SLOT_COUNT    = SLOTS_DEF;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int SETTLE_CYCLES  = 600;
   localparam int HOLD_CYCLES    = 600;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             last;
   } position_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_opcode = OP_FLAG;
   logic                 req_mutated = 1'b0;
   logic                 req_last_in_read = 1'b0;
   logic [ROW_W-1:0]     req_table_pattern = '0;
   logic [SLOT_IN_W-1:0] req_table_slot = '0;
   logic [OFF_W-1:0]     req_table_offset = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [POS_W-1:0]     rsp_predicted_position;
   logic                 rsp_last;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_write_data = '0;

   // predictor state
   logic [31:0]          care_bits;
   logic [WL_W-1:0]      shape_len;
   logic [PL_W-1:0]      pattern_len;
   logic [31:0]          flag_window;
   logic [11:0]          hit_history;
   int unsigned          flags_taken;
   logic [OFF_W-1:0]     offset_table [0:4095][0:7];
   logic [511:0]         position_seen;

   position_word_type expected_positions[$];

   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_left = 0;
   int mismatch_count = 0;
   int words_sent = 0;
   int table_words_sent = 0;
   int reads_done = 0;
   int words_checked = 0;

   spaced_seed_mutation_predictor_unit uut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int unsigned shape_span();
      if (shape_len == 0) return 1;
      if (shape_len > SHAPE_LIMIT) return SHAPE_LIMIT;
      return shape_len;
   endfunction

   function automatic int unsigned pattern_span();
      if (pattern_len == 0) return 1;
      if (pattern_len > PATTERN_LIMIT) return PATTERN_LIMIT;
      return pattern_len;
   endfunction

   task automatic clear_read_state();
      flag_window = '0;
      hit_history = '0;
      flags_taken = 0;
      position_seen = '0;
   endtask

   task automatic predict_positions(input logic op, input logic mut, input logic lst,
                                    input logic [ROW_W-1:0] pat,
                                    input logic [SLOT_IN_W-1:0] slot,
                                    input logic [OFF_W-1:0] off);
      int unsigned wl, pl, h, ppos, s;
      int n;
      logic hit, done;
      logic [12:0] full;
      logic [11:0] pattern;
      logic [OFF_W-1:0] offset;
      logic [31:0] sum;
      logic [POS_W-1:0] found [0:7];
      position_word_type w;
      n = 0;
      if (op == OP_TABLE) begin
         offset_table[pat][slot] = off;
      end else begin
         if (flags_taken < READ_LIMIT) begin
            wl = shape_span();
            pl = pattern_span();
            full = (13'd1 << pl) - 13'd1;
            flag_window = {flag_window[30:0], mut};
            flags_taken++;
            if (flags_taken >= wl) begin
               h = flags_taken - wl;
               hit = 1'b1;
               for (int k = 0; k < wl; k++) begin
                  if (flag_window[wl-1-k] && !care_bits[k]) hit = 1'b0;
               end
               hit_history = {hit_history[10:0], hit} & full[11:0];
               if (h + 1 >= pl) begin
                  ppos = h + 1 - pl;
                  pattern = hit_history;
                  if (pattern != 0 && pattern != full[11:0]) begin
                     done = 1'b0;
                     for (s = 0; s < SLOT_COUNT && !done; s++) begin
                        offset = offset_table[pattern][s];
                        if (offset == END_MARK) begin
                           done = 1'b1;
                        end else begin
                           sum = ppos + offset;
                           if (!position_seen[sum[8:0]]) begin
                              position_seen[sum[8:0]] = 1'b1;
                              found[n] = sum[8:0];
                              n++;
                           end
                        end
                     end
                  end
               end
            end
         end
         for (int i = 0; i < n; i++) begin
            w.position = found[i];
            w.last = (i == n - 1);
            expected_positions = {expected_positions, w};
         end
         if (lst) clear_read_state();
      end
   endtask

   task automatic send_word(input logic op, input logic mut, input logic lst,
                            input logic [ROW_W-1:0] pat, input logic [SLOT_IN_W-1:0] slot,
                            input logic [OFF_W-1:0] off);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_mutated <= mut;
      req_last_in_read <= lst;
      req_table_pattern <= pat;
      req_table_slot <= slot;
      req_table_offset <= off;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_positions(op, mut, lst, pat, slot, off);
      words_sent++;
      if (op == OP_TABLE) table_words_sent++;
   endtask

   task automatic send_flag(input logic mut, input logic lst);
      send_word(OP_FLAG, mut, lst, ROW_W'($urandom_range(4095)),
                SLOT_IN_W'($urandom_range(7)), OFF_W'($urandom_range(255)));
   endtask

   task automatic send_table_word(input logic [ROW_W-1:0] row,
                                  input logic [SLOT_IN_W-1:0] slot,
                                  input logic [OFF_W-1:0] off);
      send_word(OP_TABLE, 1'($urandom_range(1)), 1'($urandom_range(1)), row, slot, off);
   endtask

   function automatic logic [OFF_W-1:0] random_offset();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8) return END_MARK;
      if (r < 55) return OFF_W'($urandom_range(15));
      return OFF_W'($urandom_range(254));
   endfunction

   task automatic fill_row(input logic [ROW_W-1:0] row, input int max_slots);
      int n;
      n = $urandom_range(1, max_slots);
      for (int s = 0; s < n; s++) send_table_word(row, SLOT_IN_W'(s), random_offset());
   endtask

   task automatic write_settings(input logic [31:0] cm, input logic [WL_W-1:0] wl,
                                 input logic [PL_W-1:0] pl);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_CARE_MASK;
      csr_write_data <= cm;
      @(posedge clock);
      csr_index <= CSR_WINDOW_LENGTH;
      csr_write_data <= {{(CSR_W-WL_W){1'b0}}, wl};
      @(posedge clock);
      csr_index <= CSR_PATTERN_LENGTH;
      csr_write_data <= {{(CSR_W-PL_W){1'b0}}, pl};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      care_bits = cm;
      shape_len = wl;
      pattern_len = pl;
   endtask

   // wait for every expected word, then let the block finish any scan or sweep
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_positions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_reads(input int n_flags, input int min_len, input int max_len,
                            input int mut_pct, input int long_pct);
      int sent, len, r;
      logic first;
      sent = 0;
      first = 1'b1;
      while (sent < n_flags) begin
         r = $urandom_range(99);
         if (long_pct > 0 && (first || r < long_pct))
            len = $urandom_range(READ_LIMIT + 1, READ_LIMIT + 12);
         else if (r >= 90)
            len = $urandom_range(1, 3);
         else
            len = $urandom_range(min_len, max_len);
         first = 1'b0;
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 4)
               send_table_word(ROW_W'($urandom_range(4095)), SLOT_IN_W'($urandom_range(7)),
                               random_offset());
            send_flag($urandom_range(99) < mut_pct, i == len - 1);
         end
         sent += len;
         reads_done++;
      end
   endtask

   // all-ones hits under the reset shape never look anything up
   task automatic test_reset_defaults();
      send_table_word(12'hFF, 0, 8'd3);
      send_flag(1'b1, 1'b0);
      send_flag(1'b0, 1'b1);
      reads_done++;
   endtask

   task automatic test_table_lookup();
      logic [OFF_W-1:0] row_offsets [0:7];
      row_offsets = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd253, 8'd254};
      settle();
      write_settings(32'h0000_0000, 6'd1, 4'd3);
      for (int s = 0; s < 8; s++) send_table_word(12'd6, SLOT_IN_W'(s), row_offsets[s]);
      send_table_word(12'd5, 0, 8'd9);
      send_table_word(12'd5, 1, END_MARK);
      // short window, full row, end mark, empty row, partial repeats, all zeros
      send_flag(1'b0, 1'b0);
      send_flag(1'b0, 1'b0);
      send_flag(1'b1, 1'b0);
      send_flag(1'b0, 1'b0);
      send_flag(1'b0, 1'b0);
      send_flag(1'b1, 1'b0);
      send_flag(1'b1, 1'b0);
      send_flag(1'b1, 1'b1);
      // all ones skipped, then the map must have been cleared
      send_flag(1'b0, 1'b0);
      send_flag(1'b0, 1'b0);
      send_flag(1'b0, 1'b0);
      send_flag(1'b1, 1'b1);
      reads_done += 2;
   endtask

   task automatic test_clamped_lengths();
      settle();
      write_settings(32'hFFFF_0000, 6'd0, 4'd0);
      send_flag(1'b1, 1'b0);
      send_flag(1'b0, 1'b0);
      send_flag(1'b1, 1'b1);
      reads_done++;
   endtask

   task automatic test_mixed_reads();
      int unsigned pl;
      settle();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      pl = $urandom_range(2, 5);
      write_settings($urandom, WL_W'($urandom_range(2, 6)), PL_W'(pl));
      for (int i = 0; i < 5; i++) fill_row(ROW_W'($urandom_range(1, (1 << pl) - 2)), 8);
      run_reads(40, 6, 30, 30, 0);
   endtask

   task automatic fill_single_gap_rows();
      for (int j = 0; j < 12; j++) fill_row(12'hFFF ^ (12'd1 << j), 5);
   endtask

   task automatic test_long_shape();
      settle();
      req_idle_pct = 87;
      rsp_stall_pct = 0;
      write_settings(~(32'd1 << $urandom_range(31)), 6'd32, 4'd12);
      fill_single_gap_rows();
      run_reads(100, 50, 100, 4, 30);
   endtask

   task automatic test_receiver_stall();
      settle();
      req_idle_pct = 0;
      rsp_stall_pct = 87;
      write_settings(32'h0000_0000, 6'd1, 4'd3);
      for (int r = 1; r < 7; r++) fill_row(ROW_W'(r), 8);
      run_reads(45, 4, 20, 40, 0);
   endtask

   task automatic test_clamped_shape();
      settle();
      req_idle_pct = 14;
      rsp_stall_pct = 14;
      write_settings(~(32'd1 << $urandom_range(31)), WL_W'($urandom_range(33, 63)),
                     PL_W'($urandom_range(13, 15)));
      fill_single_gap_rows();
      run_reads(45, 45, 90, 4, 0);
   endtask

   task automatic test_backpressure();
      settle();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      write_settings(32'h0000_0002, 6'd2, 4'd3);
      rsp_hold_left = HOLD_CYCLES;
      run_reads(30, 10, 20, 40, 0);
   endtask

   task automatic check_position();
      position_word_type want;
      if (expected_positions.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected word: position %0d last %0b",
                     rsp_predicted_position, rsp_last);
      end else begin
         want = expected_positions.pop_front();
         words_checked++;
         if (want.position !== rsp_predicted_position || want.last !== rsp_last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: expected position %0d last %0b, got position %0d last %0b",
                        want.position, want.last, rsp_predicted_position, rsp_last);
         end
      end
   endtask

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) check_position();
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : main
      for (int r = 0; r < 4096; r++)
         for (int s = 0; s < 8; s++) offset_table[r][s] = END_MARK;
      clear_read_state();
      care_bits = 32'hFFFF_FFFF;
      shape_len = 6'd1;
      pattern_len = 4'd8;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_table_lookup();
      test_clamped_lengths();
      test_mixed_reads();
      test_long_shape();
      test_receiver_stall();
      test_clamped_shape();
      test_backpressure();
      settle();
      $display("covered %0d request words (%0d table words) in %0d reads, %0d positions checked",
               words_sent, table_words_sent, reads_done, words_checked);
      $display("shapes from 1 to 32 positions, patterns from 1 to 12 bits, %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
